### design/mmts_pkg.sv
// Shared types and constants for the min/max tracking stack.
// No dependencies; the controller, datapath, top level and checker import this package.
`timescale 1ns / 1ps

package mmts_pkg;

	localparam int DATA_W        = 32;
	localparam int LEN_W         = 11;
	localparam int CMD_W         = 2;
	localparam int STAT_W        = 2;
	localparam int DEFAULT_DEPTH = 1024;

	localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_TOP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic execute;
		logic load_out;
	} ctrl_cmd_t;

endpackage

### design/mmts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mmts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/mmts_ctrl.sv
// Sequencer for the min/max tracking stack: input handshake, step control,
// output valid register. Depends on mmts_pkg.
`timescale 1ns / 1ps

module mmts_ctrl
	import mmts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: state_d = ST_TOP;
			ST_TOP:  state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = (state_q != ST_IDLE);
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.execute  = (state_q == ST_EXEC);
		cmd.load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### design/mmts_dp.sv
// Datapath of the min/max tracking stack: three stack RAMs, their counters,
// the push/pop decisions and the result registers. Depends on mmts_pkg, mmts_ram.
`timescale 1ns / 1ps

module mmts_dp
	import mmts_pkg::*;
#(
	parameter int STACK_DEPTH = DEFAULT_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_cmd_t                cmd,
	input  logic [CMD_W-1:0]         in_cmd,
	input  logic signed [DATA_W-1:0] in_value,
	output logic signed [DATA_W-1:0] popped_value,
	output logic signed [DATA_W-1:0] current_min,
	output logic signed [DATA_W-1:0] current_max,
	output logic [LEN_W-1:0]         stack_length,
	output logic [STAT_W-1:0]        status
);

	localparam int AW    = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

	logic [CMD_W-1:0]  cmd_q;
	logic [DATA_W-1:0] val_q;
	logic [CNT_W-1:0]  vcnt_q, mcnt_q, xcnt_q;
	logic [CNT_W-1:0]  vcnt_d, mcnt_d, xcnt_d;
	logic [DATA_W-1:0] popped_q, popped_d;
	logic [STAT_W-1:0] stat_q, stat_d;
	logic              v_we, m_we, x_we;
	logic [AW-1:0]     v_ra, m_ra, x_ra;
	logic [DATA_W-1:0] v_rd, m_rd, x_rd;

	logic signed [DATA_W-1:0] res_pop_q, res_min_q, res_max_q;
	logic [LEN_W-1:0]         res_len_q;
	logic [STAT_W-1:0]        res_stat_q;

	// read ports always address the current tops
	assign v_ra = (vcnt_q == '0) ? '0 : AW'(vcnt_q - CNT_W'(1));
	assign m_ra = (mcnt_q == '0) ? '0 : AW'(mcnt_q - CNT_W'(1));
	assign x_ra = (xcnt_q == '0) ? '0 : AW'(xcnt_q - CNT_W'(1));

	mmts_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_val_ram (
		.clk(clk), .we(v_we), .waddr(AW'(vcnt_q)), .wdata(val_q),
		.raddr(v_ra), .rdata(v_rd)
	);

	mmts_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_min_ram (
		.clk(clk), .we(m_we), .waddr(AW'(mcnt_q)), .wdata(val_q),
		.raddr(m_ra), .rdata(m_rd)
	);

	mmts_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_max_ram (
		.clk(clk), .we(x_we), .waddr(AW'(xcnt_q)), .wdata(val_q),
		.raddr(x_ra), .rdata(x_rd)
	);

	always_comb begin
		vcnt_d   = vcnt_q;
		mcnt_d   = mcnt_q;
		xcnt_d   = xcnt_q;
		v_we     = 1'b0;
		m_we     = 1'b0;
		x_we     = 1'b0;
		popped_d = '0;
		stat_d   = STAT_OK;
		if (cmd_q == CMD_PUSH) begin
			if (vcnt_q >= DEPTH_C) begin
				stat_d = STAT_OVERFLOW;
			end else begin
				v_we   = cmd.execute;
				vcnt_d = vcnt_q + CNT_W'(1);
				if ((mcnt_q == '0 || $signed(val_q) <= $signed(m_rd)) && mcnt_q < DEPTH_C) begin
					m_we   = cmd.execute;
					mcnt_d = mcnt_q + CNT_W'(1);
				end
				if ((xcnt_q == '0 || $signed(val_q) >= $signed(x_rd)) && xcnt_q < DEPTH_C) begin
					x_we   = cmd.execute;
					xcnt_d = xcnt_q + CNT_W'(1);
				end
			end
		end else if (cmd_q == CMD_POP) begin
			if (vcnt_q == '0) begin
				stat_d = STAT_UNDERFLOW;
			end else begin
				vcnt_d   = vcnt_q - CNT_W'(1);
				popped_d = v_rd;
				if (mcnt_q != '0 && m_rd == v_rd) begin
					mcnt_d = mcnt_q - CNT_W'(1);
				end
				if (xcnt_q != '0 && x_rd == v_rd) begin
					xcnt_d = xcnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q <= '0;
			mcnt_q <= '0;
			xcnt_q <= '0;
		end else if (cmd.execute) begin
			vcnt_q <= vcnt_d;
			mcnt_q <= mcnt_d;
			xcnt_q <= xcnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= in_cmd;
			val_q <= in_value;
		end
		if (cmd.execute) begin
			popped_q <= popped_d;
			stat_q   <= stat_d;
		end
		// read data here reflects the tops after the update
		if (cmd.load_out) begin
			res_pop_q  <= popped_q;
			res_min_q  <= (vcnt_q != '0 && mcnt_q != '0) ? m_rd : '0;
			res_max_q  <= (vcnt_q != '0 && xcnt_q != '0) ? x_rd : '0;
			res_len_q  <= LEN_W'(vcnt_q);
			res_stat_q <= stat_q;
		end
	end

	assign popped_value = res_pop_q;
	assign current_min  = res_min_q;
	assign current_max  = res_max_q;
	assign stack_length = res_len_q;
	assign status       = res_stat_q;

endmodule

### design/min_max_tracking_stack_unit.sv
// Top level of the min/max tracking stack: sequencer plus datapath.
// Depends on mmts_pkg, mmts_ctrl, mmts_dp.
`timescale 1ns / 1ps

// A LIFO of signed 32-bit values that reports the current minimum and maximum
// with every transaction. cmd 0 pushes push_value, 1 pops, 2 and 3 only report.
// Each input transaction yields one result: popped value (zero unless a pop
// succeeded), min and max (zero when empty), length and status (underflow on
// an empty pop, overflow on a push into a full stack, which then changes
// nothing). An accepted item steps through ST_EXEC, ST_TOP and ST_DONE and is
// loaded into the output register in ST_DONE, later only while the previous
// result still waits there; then in_stall drops, so no new item is accepted
// before the last is loaded. ST_TOP is needed as the three stack RAMs have
// registered read ports, read once at the old tops and once more at the new tops.
// A finished result may wait in the output register while the next
// transaction is accepted. The RAMs need no clearing after reset: their counters reset to zero.

module min_max_tracking_stack_unit
	import mmts_pkg::*;
#(
	parameter int STACK_DEPTH = DEFAULT_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CMD_W-1:0]         cmd,
	input  logic signed [DATA_W-1:0] push_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] popped_value,
	output logic signed [DATA_W-1:0] current_min,
	output logic signed [DATA_W-1:0] current_max,
	output logic [LEN_W-1:0]         stack_length,
	output logic [STAT_W-1:0]        status
);

	ctrl_cmd_t ctl;

	mmts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (ctl)
	);

	mmts_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (ctl),
		.in_cmd      (cmd),
		.in_value    (push_value),
		.popped_value(popped_value),
		.current_min (current_min),
		.current_max (current_max),
		.stack_length(stack_length),
		.status      (status)
	);

endmodule

### design/mmts_checker.sv
// Port-level checks for the min/max tracking stack, bound to the top level.
// Depends on mmts_pkg and min_max_tracking_stack_unit.
`timescale 1ns / 1ps

module mmts_checker
	import mmts_pkg::*;
#(
	parameter int STACK_DEPTH = DEFAULT_DEPTH
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [DATA_W-1:0] popped_value,
	input logic signed [DATA_W-1:0] current_min,
	input logic signed [DATA_W-1:0] current_max,
	input logic [LEN_W-1:0]         stack_length,
	input logic [STAT_W-1:0]        status
);

	localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(STACK_DEPTH);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(current_min) && $stable(status))
		else $error("result changed while stalled");

	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_UNDERFLOW |-> stack_length == '0 && popped_value == '0)
		else $error("underflow with nonempty stack or nonzero value");

	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_OVERFLOW |-> stack_length == FULL_LEN && popped_value == '0)
		else $error("overflow reported below full depth");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stack_length != '0 |-> current_min <= current_max)
		else $error("min above max");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stack_length == '0 && STACK_DEPTH < (1 << LEN_W)
		|-> current_min == '0 && current_max == '0)
		else $error("empty stack with nonzero min or max");

endmodule

bind min_max_tracking_stack_unit mmts_checker #(.STACK_DEPTH(STACK_DEPTH)) u_mmts_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.popped_value(popped_value),
	.current_min (current_min),
	.current_max (current_max),
	.stack_length(stack_length),
	.status      (status)
);
